[rtl/core/fwq_pkg.sv]
package fwq_pkg;

    localparam int MAX_WAITERS_DEF    = 32;
    localparam int THREAD_ID_BITS_DEF = 8;
    localparam int ADDRESS_BITS_DEF   = 48;

    localparam int OPCODE_W = 9;
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_WAIT            = 7'd0;
    localparam logic [CMD_W-1:0] CMD_WAKE            = 7'd1;
    localparam logic [CMD_W-1:0] CMD_REQUEUE         = 7'd3;
    localparam logic [CMD_W-1:0] CMD_WAIT_BITSET     = 7'd9;
    localparam logic [CMD_W-1:0] CMD_WAKE_BITSET     = 7'd10;
    localparam logic [CMD_W-1:0] CMD_WAIT_REQUEUE_PI = 7'd11;

    localparam int OP_REALTIME_BIT = 8;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RETRY         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_SUPPORTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL    = 2'd3;

    typedef struct packed {
        logic pop;
        logic push;
    } t_chain_ctrl;

endpackage

[rtl/core/futex_wait_queue_engine.sv]
// Futex wait queue held as one first-in first-out row of cells that shift towards the head.
// Wait, not-supported and retry transactions go from idle straight to the status state. Wake
// and withdraw rotate every waiter once through the head cell; a wake stalls while the result
// side is not ready to take a woken thread. Requeue rotates the list twice and then drains
// the moved threads from a side row back to the tail. Each transaction ends with one status
// result marked by tlast.
module futex_wait_queue_engine #(
    parameter int MAX_WAITERS    = fwq_pkg::MAX_WAITERS_DEF,
    parameter int THREAD_ID_BITS = fwq_pkg::THREAD_ID_BITS_DEF,
    parameter int ADDRESS_BITS   = fwq_pkg::ADDRESS_BITS_DEF,
    localparam int IN_BITS  = fwq_pkg::OPCODE_W + THREAD_ID_BITS + 2 * ADDRESS_BITS
                              + 3 * fwq_pkg::WORD_W,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = THREAD_ID_BITS + fwq_pkg::STATUS_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // opcode, thread_id, addr, addr2, current_value, value_or_count, second_count
    input  logic [IN_W-1:0] i_s_axis_tdata,
    // withdraw
    input  logic            i_s_axis_tuser,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // woken_thread, status
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // kind
    output logic            o_m_axis_tuser,
    output logic            o_m_axis_tlast
);

    localparam int TB    = THREAD_ID_BITS;
    localparam int AB    = ADDRESS_BITS;
    localparam int WW    = fwq_pkg::WORD_W;
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam int ENT_W = AB + TB;
    localparam int OFS_TID  = fwq_pkg::OPCODE_W;
    localparam int OFS_A    = OFS_TID + TB;
    localparam int OFS_A2   = OFS_A + AB;
    localparam int OFS_CUR  = OFS_A2 + AB;
    localparam int OFS_V    = OFS_CUR + WW;
    localparam int OFS_C2   = OFS_V + WW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAKE,
        S_MOVE,
        S_DRAIN,
        S_WD,
        S_STATUS
    } t_state;

    t_state r_state;

    logic [AB-1:0]    r_addr;
    logic [AB-1:0]    r_addr2;
    logic [TB-1:0]    r_tid;
    logic [WW-1:0]    r_c2;
    logic [WW-1:0]    r_lim;
    logic [CNT_W-1:0] r_left;
    logic             r_req;
    logic             r_found;
    logic [fwq_pkg::STATUS_W-1:0] r_status;

    logic             r_out_valid;
    logic             r_out_kind;
    logic [TB-1:0]    r_out_thr;
    logic [fwq_pkg::STATUS_W-1:0] r_out_status;
    logic             r_out_last;

    fwq_pkg::t_chain_ctrl main_ctrl;
    fwq_pkg::t_chain_ctrl side_ctrl;
    logic [ENT_W-1:0] main_push;
    logic [ENT_W-1:0] main_head;
    logic [CNT_W-1:0] main_occ;
    logic [TB-1:0]    side_head;
    logic [CNT_W-1:0] side_occ;

    logic [fwq_pkg::OPCODE_W-1:0] in_op;
    logic [fwq_pkg::CMD_W-1:0]    in_cmd;
    logic [TB-1:0]    in_tid;
    logic [AB-1:0]    in_addr;
    logic [WW-1:0]    in_cur;
    logic [WW-1:0]    in_v;
    logic             in_accept;
    logic             in_rt_bad;
    logic             in_is_wait;
    logic             in_append;
    logic             out_free;
    logic             head_match;
    logic             lim_nz;
    logic             emit_wake;
    logic             emit_status;

    assign in_op   = i_s_axis_tdata[fwq_pkg::OPCODE_W-1:0];
    assign in_cmd  = in_op[fwq_pkg::CMD_W-1:0];
    assign in_tid  = i_s_axis_tdata[OFS_TID +: TB];
    assign in_addr = i_s_axis_tdata[OFS_A +: AB];
    assign in_cur  = i_s_axis_tdata[OFS_CUR +: WW];
    assign in_v    = i_s_axis_tdata[OFS_V +: WW];

    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_rt_bad  = in_op[fwq_pkg::OP_REALTIME_BIT]
                        && !(in_cmd inside {fwq_pkg::CMD_WAIT, fwq_pkg::CMD_WAIT_BITSET,
                                            fwq_pkg::CMD_WAIT_REQUEUE_PI});
    assign in_is_wait = in_cmd inside {fwq_pkg::CMD_WAIT, fwq_pkg::CMD_WAIT_BITSET};
    assign in_append  = in_accept && !i_s_axis_tuser && !in_rt_bad && in_is_wait
                        && (in_cur == in_v) && (main_occ < CNT_W'(MAX_WAITERS));

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign head_match = main_head[TB +: AB] == r_addr;
    assign lim_nz     = r_lim != '0;

    always_comb begin
        main_ctrl   = '0;
        side_ctrl   = '0;
        main_push   = main_head;
        emit_wake   = 1'b0;
        emit_status = 1'b0;
        case (r_state)
            S_IDLE: begin
                main_ctrl.push = in_append;
                main_push      = {in_addr, in_tid};
            end
            S_WAKE: begin
                if (r_left != '0) begin
                    if (head_match && lim_nz) begin
                        emit_wake     = out_free;
                        main_ctrl.pop = out_free;
                    end else begin
                        main_ctrl.pop  = 1'b1;
                        main_ctrl.push = 1'b1;
                    end
                end
            end
            S_MOVE: begin
                if (r_left != '0) begin
                    main_ctrl.pop = 1'b1;
                    if (head_match && lim_nz) begin
                        side_ctrl.push = 1'b1;
                    end else begin
                        main_ctrl.push = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (side_occ != '0) begin
                    side_ctrl.pop  = 1'b1;
                    main_ctrl.push = 1'b1;
                    main_push      = {r_addr2, side_head};
                end
            end
            S_WD: begin
                if (r_left != '0) begin
                    main_ctrl.pop = 1'b1;
                    main_ctrl.push = !((main_head[TB-1:0] == r_tid) && !r_found);
                end
            end
            S_STATUS: begin
                emit_status = out_free;
            end
            default: begin
            end
        endcase
    end

    fwq_chain #(
        .DEPTH(MAX_WAITERS),
        .WIDTH(ENT_W),
        .CNT_W(CNT_W)
    ) u_main (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (main_ctrl),
        .i_push_data(main_push),
        .o_head     (main_head),
        .o_occ      (main_occ)
    );

    fwq_chain #(
        .DEPTH(MAX_WAITERS),
        .WIDTH(TB),
        .CNT_W(CNT_W)
    ) u_side (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (side_ctrl),
        .i_push_data(main_head[TB-1:0]),
        .o_head     (side_head),
        .o_occ      (side_occ)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_wake) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= 1'b1;
                r_out_thr    <= main_head[TB-1:0];
                r_out_status <= fwq_pkg::ST_OK;
                r_out_last   <= 1'b0;
            end else if (emit_status) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= 1'b0;
                r_out_thr    <= '0;
                r_out_status <= r_status;
                r_out_last   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (main_ctrl.pop) begin
                r_left <= r_left - CNT_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_addr   <= in_addr;
                        r_addr2  <= i_s_axis_tdata[OFS_A2 +: AB];
                        r_tid    <= in_tid;
                        r_c2     <= i_s_axis_tdata[OFS_C2 +: WW];
                        r_left   <= main_occ;
                        r_found  <= 1'b0;
                        r_req    <= 1'b0;
                        r_lim    <= (in_v[WW-1] && (in_cmd inside {fwq_pkg::CMD_WAKE,
                                     fwq_pkg::CMD_WAKE_BITSET})) ? '0 : in_v;
                        if (i_s_axis_tuser) begin
                            r_status <= fwq_pkg::ST_OK;
                            r_state  <= S_WD;
                        end else if (in_rt_bad) begin
                            r_status <= fwq_pkg::ST_NOT_SUPPORTED;
                            r_state  <= S_STATUS;
                        end else if (in_is_wait) begin
                            if (in_cur != in_v) begin
                                r_status <= fwq_pkg::ST_RETRY;
                            end else if (!in_append) begin
                                r_status <= fwq_pkg::ST_TABLE_FULL;
                            end else begin
                                r_status <= fwq_pkg::ST_OK;
                            end
                            r_state <= S_STATUS;
                        end else if (in_cmd inside {fwq_pkg::CMD_WAKE,
                                                    fwq_pkg::CMD_WAKE_BITSET}) begin
                            r_status <= fwq_pkg::ST_OK;
                            r_state  <= S_WAKE;
                        end else if (in_cmd == fwq_pkg::CMD_REQUEUE) begin
                            r_status <= fwq_pkg::ST_OK;
                            r_req    <= 1'b1;
                            r_state  <= S_WAKE;
                        end else begin
                            r_status <= fwq_pkg::ST_NOT_SUPPORTED;
                            r_state  <= S_STATUS;
                        end
                    end
                end
                S_WAKE: begin
                    if (emit_wake) begin
                        r_lim <= r_lim - WW'(1);
                    end
                    if (r_left == '0) begin
                        if (r_req) begin
                            r_lim   <= r_c2;
                            r_left  <= main_occ;
                            r_state <= S_MOVE;
                        end else begin
                            r_state <= S_STATUS;
                        end
                    end
                end
                S_MOVE: begin
                    if (side_ctrl.push) begin
                        r_lim <= r_lim - WW'(1);
                    end
                    if (r_left == '0) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (side_occ == '0) begin
                        r_state <= S_STATUS;
                    end
                end
                S_WD: begin
                    if (main_ctrl.pop && !main_ctrl.push) begin
                        r_found <= 1'b1;
                    end
                    if (r_left == '0) begin
                        r_state <= S_STATUS;
                    end
                end
                S_STATUS: begin
                    if (emit_status) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_status, r_out_thr});
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (main_occ + side_occ) <= CNT_W'(MAX_WAITERS))
        else $error("waiter rows hold more entries than the list depth");

    a_side_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (side_occ == '0))
        else $error("side row not empty between transactions");

    a_woken_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> !o_m_axis_tlast)
        else $error("woken thread result marked as final");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STATUS && out_free) |=> (r_state == S_IDLE && o_m_axis_tlast))
        else $error("status result did not close the transaction");

endmodule

[rtl/core/fwq_cell.sv]
module fwq_cell #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_load,
    input  logic [WIDTH-1:0] i_load_data,
    input  logic [WIDTH-1:0] i_next_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/core/fwq_chain.sv]
module fwq_chain #(
    parameter int DEPTH = fwq_pkg::MAX_WAITERS_DEF,
    parameter int WIDTH = 8,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fwq_pkg::t_chain_ctrl i_ctrl,
    input  logic [WIDTH-1:0]    i_push_data,
    output logic [WIDTH-1:0]    o_head,
    output logic [CNT_W-1:0]    o_occ
);

    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] wr_idx;
    logic [WIDTH-1:0] cell_q [DEPTH];

    assign wr_idx = i_ctrl.pop ? r_occ - CNT_W'(1) : r_occ;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] next_data;
        if (i == DEPTH - 1) begin : g_end
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = cell_q[i+1];
        end
        fwq_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_ctrl.pop),
            .i_load     (i_ctrl.push && (wr_idx == CNT_W'(i))),
            .i_load_data(i_push_data),
            .i_next_data(next_data),
            .o_data     (cell_q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_ctrl.push && !i_ctrl.pop) begin
            r_occ <= r_occ + CNT_W'(1);
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            r_occ <= r_occ - CNT_W'(1);
        end
    end

    assign o_head = cell_q[0];
    assign o_occ  = r_occ;

endmodule
